### rtl/core/nns_pkg.sv
// Shared types and codes for the nearest node search block.
`timescale 1ns / 1ps

package nns_pkg;

    localparam int DIMS       = 7;
    localparam int FUNC_W     = 2;
    localparam int COORD_IO_W = 16;
    localparam int IDX_OUT_W  = 10;
    localparam int DIST_OUT_W = 35;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic wr_en;
        logic load_q;
        logic rd_en;
    } t_lane_ctrl;

    typedef struct packed {
        logic start;
        logic valid;
    } t_merge_ctrl;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]                 node_index;
        logic [DIMS-1:0][COORD_IO_W-1:0]      near;
        logic [DIST_OUT_W-1:0]                squared_distance;
        logic [STATUS_W-1:0]                  status;
    } t_result;

endpackage

### rtl/core/nns_if.sv
// Request and result channel interfaces of the nearest node search block.
`timescale 1ns / 1ps

interface nns_in_if;
    import nns_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [FUNC_W-1:0]             func;
    logic signed [COORD_IO_W-1:0]  joint_0;
    logic signed [COORD_IO_W-1:0]  joint_1;
    logic signed [COORD_IO_W-1:0]  joint_2;
    logic signed [COORD_IO_W-1:0]  joint_3;
    logic signed [COORD_IO_W-1:0]  joint_4;
    logic signed [COORD_IO_W-1:0]  joint_5;
    logic signed [COORD_IO_W-1:0]  joint_6;

    modport source (
        output valid, func, joint_0, joint_1, joint_2, joint_3, joint_4, joint_5, joint_6,
        input  ready
    );
    modport sink (
        input  valid, func, joint_0, joint_1, joint_2, joint_3, joint_4, joint_5, joint_6,
        output ready
    );
endinterface

interface nns_out_if;
    import nns_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [IDX_OUT_W-1:0]          node_index;
    logic signed [COORD_IO_W-1:0]  near_0;
    logic signed [COORD_IO_W-1:0]  near_1;
    logic signed [COORD_IO_W-1:0]  near_2;
    logic signed [COORD_IO_W-1:0]  near_3;
    logic signed [COORD_IO_W-1:0]  near_4;
    logic signed [COORD_IO_W-1:0]  near_5;
    logic signed [COORD_IO_W-1:0]  near_6;
    logic [DIST_OUT_W-1:0]         squared_distance;
    logic [STATUS_W-1:0]           status;

    modport source (
        output valid, node_index, near_0, near_1, near_2, near_3, near_4, near_5, near_6,
               squared_distance, status,
        input  ready
    );
    modport sink (
        input  valid, node_index, near_0, near_1, near_2, near_3, near_4, near_5, near_6,
               squared_distance, status,
        output ready
    );
endinterface

### rtl/core/nns_lane.sv
// One joint lane: coordinate memory, query register and squared difference.
`timescale 1ns / 1ps

module nns_lane #(
    parameter int MAX_NODES   = 1024,
    parameter int COORD_WIDTH = 16,
    parameter int IW          = $clog2(MAX_NODES),
    parameter int SQ_W        = 2 * COORD_WIDTH + 2
) (
    input  logic                    i_clk,
    input  nns_pkg::t_lane_ctrl     i_ctrl,
    input  logic [IW-1:0]           i_addr,
    input  logic [COORD_WIDTH-1:0]  i_wdata,
    output logic [COORD_WIDTH-1:0]  o_rdata,
    output logic [SQ_W-1:0]         o_sq
);
    import nns_pkg::*;

    logic [COORD_WIDTH-1:0] r_mem [MAX_NODES];
    logic [COORD_WIDTH-1:0] r_q;
    logic [COORD_WIDTH-1:0] r_rd;
    logic [SQ_W-1:0]        r_sq;

    logic signed [COORD_WIDTH:0] w_diff;
    logic signed [SQ_W-1:0]      w_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // The difference of two signed coordinates squared is never negative.
    assign w_diff = $signed({r_q[COORD_WIDTH-1], r_q}) - $signed({r_rd[COORD_WIDTH-1], r_rd});
    assign w_prod = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_q) begin
            r_q <= i_wdata;
        end
        r_sq <= w_prod;
    end

    assign o_rdata = r_rd;
    assign o_sq    = r_sq;

endmodule

### rtl/core/nns_merge.sv
// Sums the lane squares over a registered adder tree and keeps the running minimum.
`timescale 1ns / 1ps

module nns_merge #(
    parameter int IW    = 10,
    parameter int SQ_W  = 34,
    parameter int SUM_W = SQ_W + 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  nns_pkg::t_merge_ctrl                   i_ctrl,
    input  logic [IW-1:0]                          i_idx,
    input  logic [nns_pkg::DIMS-1:0][SQ_W-1:0]     i_sq,
    output logic                                   o_busy,
    output logic [IW-1:0]                          o_best_idx,
    output logic [SUM_W-1:0]                       o_best_dist
);
    import nns_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic [IW-1:0]      r_idx1, r_idx2, r_idx3;
    logic [SQ_W:0]      r_p [4];
    logic [SQ_W+1:0]    r_s [2];
    logic [SUM_W-1:0]   r_tot;
    logic               r_have;
    logic [IW-1:0]      r_best_idx;
    logic [SUM_W-1:0]   r_best_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_ctrl.start) begin
                r_have <= 1'b0;
            end else if (r_v3) begin
                r_have <= 1'b1;
            end
        end
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_p[0] <= {1'b0, i_sq[0]} + {1'b0, i_sq[1]};
        r_p[1] <= {1'b0, i_sq[2]} + {1'b0, i_sq[3]};
        r_p[2] <= {1'b0, i_sq[4]} + {1'b0, i_sq[5]};
        r_p[3] <= {1'b0, i_sq[6]};
        r_s[0] <= {1'b0, r_p[0]} + {1'b0, r_p[1]};
        r_s[1] <= {1'b0, r_p[2]} + {1'b0, r_p[3]};
        r_tot  <= {1'b0, r_s[0]} + {1'b0, r_s[1]};
        // Strict compare keeps the lowest index among equal distances.
        if (r_v3 && (!r_have || r_tot < r_best_dist)) begin
            r_best_dist <= r_tot;
            r_best_idx  <= r_idx3;
        end
    end

    assign o_busy      = r_v1 | r_v2 | r_v3;
    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_dist;

endmodule

### rtl/core/nearest_node_search_7d.sv
// Top level of the nearest node search: seven joint lanes, merge stage and control.
`timescale 1ns / 1ps

// Channel  Direction  Handshake      Payload
// i_in     sink       valid / ready  func, joint_0 .. joint_6
// o_out    source     valid / ready  node_index, near_0 .. near_6, squared_distance, status
//
// Clear, insert and the unused code are answered from the idle state; the result is registered.
// A query scans the table: one stored node is read from the seven lane
// memories per cycle, then lane and adder tree latency drain, then one extra read
// fetches the winning coordinates. Reset empties the table at once (no clearing pass,
// the store is undefined until written). A stalled result waits in the output register
// while one more item is accepted; its result waits in a second register.

module nearest_node_search_7d #(
    parameter int MAX_NODES   = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nns_in_if.sink            i_in,
    nns_out_if.source         o_out
);
    import nns_pkg::*;

    localparam int IW    = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int SQ_W  = 2 * COORD_WIDTH + 2;
    localparam int SUM_W = SQ_W + 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_FETCH_WAIT
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IW-1:0]     r_addr, n_addr;
    logic [1:0]        r_tag_v, n_tag_v;
    logic [IW-1:0]     r_tag_idx0, r_tag_idx1;
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              w_in_fire;
    logic              w_not_full;
    t_lane_ctrl        w_lane_ctrl;
    t_merge_ctrl       w_merge_ctrl;
    logic [IW-1:0]     w_lane_addr;

    logic [DIMS-1:0][COORD_IO_W-1:0]  w_joint;
    logic [DIMS-1:0][COORD_WIDTH-1:0] w_wdata;
    logic [DIMS-1:0][COORD_WIDTH-1:0] w_rdata;
    logic [DIMS-1:0][COORD_IO_W-1:0]  w_near;
    logic [DIMS-1:0][SQ_W-1:0]        w_sq;

    logic              w_busy;
    logic [IW-1:0]     w_best_idx;
    logic [SUM_W-1:0]  w_best_dist;

    // Width adapters: zero padding on the high side, then keep the low bits.
    logic [IW+IDX_OUT_W-1:0]     w_best_idx_ext;
    logic [CNT_W+IDX_OUT_W-1:0]  w_count_ext;
    logic [SUM_W+DIST_OUT_W-1:0] w_dist_ext;

    assign w_joint[0] = i_in.joint_0;
    assign w_joint[1] = i_in.joint_1;
    assign w_joint[2] = i_in.joint_2;
    assign w_joint[3] = i_in.joint_3;
    assign w_joint[4] = i_in.joint_4;
    assign w_joint[5] = i_in.joint_5;
    assign w_joint[6] = i_in.joint_6;

    assign w_best_idx_ext = {{IDX_OUT_W{1'b0}}, w_best_idx};
    assign w_count_ext    = {{IDX_OUT_W{1'b0}}, r_count};
    assign w_dist_ext     = {{DIST_OUT_W{1'b0}}, w_best_dist};

    // New items are taken only between operations and while the second result
    // register is free, so any result produced always has a place to go.
    assign i_in.ready = (r_state == S_IDLE) && !r_res_valid;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_not_full = r_count < CNT_W'(MAX_NODES);

    always_comb begin
        w_lane_ctrl.wr_en  = w_in_fire && (i_in.func == FUNC_INSERT) && w_not_full;
        w_lane_ctrl.load_q = w_in_fire && (i_in.func == FUNC_QUERY);
        w_lane_ctrl.rd_en  = (r_state == S_SCAN) || (r_state == S_FETCH);
        w_merge_ctrl.start = w_lane_ctrl.load_q;
        w_merge_ctrl.valid = r_tag_v[1];
        case (r_state)
            S_SCAN:  w_lane_addr = r_addr;
            S_FETCH: w_lane_addr = w_best_idx;
            default: w_lane_addr = r_count[IW-1:0];
        endcase
    end

    for (genvar g = 0; g < DIMS; g++) begin : g_lane
        logic [COORD_WIDTH+COORD_IO_W-1:0] w_in_ext;
        logic [COORD_IO_W+COORD_WIDTH-1:0] w_out_ext;

        // Inputs are read as COORD_WIDTH-bit values; results show the low 16 bits.
        assign w_in_ext   = {{COORD_WIDTH{1'b0}}, w_joint[g]};
        assign w_wdata[g] = w_in_ext[COORD_WIDTH-1:0];
        assign w_out_ext  = {{COORD_IO_W{1'b0}}, w_rdata[g]};
        assign w_near[g]  = w_out_ext[COORD_IO_W-1:0];

        nns_lane #(
            .MAX_NODES   (MAX_NODES),
            .COORD_WIDTH (COORD_WIDTH),
            .IW          (IW),
            .SQ_W        (SQ_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (w_lane_ctrl),
            .i_addr  (w_lane_addr),
            .i_wdata (w_wdata[g]),
            .o_rdata (w_rdata[g]),
            .o_sq    (w_sq[g])
        );
    end

    nns_merge #(
        .IW    (IW),
        .SQ_W  (SQ_W),
        .SUM_W (SUM_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_merge_ctrl),
        .i_idx       (r_tag_idx1),
        .i_sq        (w_sq),
        .o_busy      (w_busy),
        .o_best_idx  (w_best_idx),
        .o_best_dist (w_best_dist)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // The scan tags follow the memory read and the lane square stage.
        n_tag_v[0] = (r_state == S_SCAN);
        n_tag_v[1] = r_tag_v[0];

        // Move the waiting result forward whenever the output register frees up.
        if (!r_out_valid || o_out.ready) begin
            n_out_valid = r_res_valid;
            n_out       = r_res;
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_res       = '0;
                    n_res.status = STATUS_OK;
                    n_res_valid = 1'b1;
                    case (i_in.func)
                        FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        FUNC_INSERT: begin
                            if (w_not_full) begin
                                n_res.node_index = w_count_ext[IDX_OUT_W-1:0];
                                n_count          = r_count + 1'b1;
                            end else begin
                                n_res.status = STATUS_FULL;
                            end
                        end
                        FUNC_QUERY: begin
                            if (r_count == '0) begin
                                n_res.status = STATUS_EMPTY;
                            end else begin
                                n_res_valid = 1'b0;
                                n_addr      = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            // The unused code leaves the table alone.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (CNT_W'(r_addr) == r_count - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_tag_v[0] && !r_tag_v[1] && !w_busy) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_FETCH_WAIT;
            end
            S_FETCH_WAIT: begin
                n_res.node_index       = w_best_idx_ext[IDX_OUT_W-1:0];
                n_res.near             = w_near;
                n_res.squared_distance = w_dist_ext[DIST_OUT_W-1:0];
                n_res.status           = STATUS_OK;
                n_res_valid            = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_tag_v     <= '0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tag_v     <= n_tag_v;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
        end
        r_addr     <= n_addr;
        r_tag_idx0 <= r_addr;
        r_tag_idx1 <= r_tag_idx0;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.node_index       = r_out.node_index;
    assign o_out.near_0           = r_out.near[0];
    assign o_out.near_1           = r_out.near[1];
    assign o_out.near_2           = r_out.near[2];
    assign o_out.near_3           = r_out.near[3];
    assign o_out.near_4           = r_out.near[4];
    assign o_out.near_5           = r_out.near[5];
    assign o_out.near_6           = r_out.near[6];
    assign o_out.squared_distance = r_out.squared_distance;
    assign o_out.status           = r_out.status;

endmodule
